// ===== rtl/core/ring_next_free_server_assigner_macros.svh =====
// Assertion macros used by the ring server assigner top level.
// Depends on nothing; files that check their own logic include it.
`ifndef RING_NEXT_FREE_SERVER_ASSIGNER_MACROS_SVH
`define RING_NEXT_FREE_SERVER_ASSIGNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RNFSA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RNFSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rnfsa_pkg.sv =====
// Types and fixed constants of the ring server assigner.
// No dependencies; used by the top level by scoped names.
package rnfsa_pkg;

	// Fixed field widths of the request and result items.
	localparam int ARRIVAL_W = 32;
	localparam int LENGTH_W  = 32;
	localparam int INDEX_W   = 4;
	localparam int BUSIEST_W = 16;
	localparam int NUM_SRV_W = 5;

	// Server count after reset.
	localparam logic [NUM_SRV_W-1:0] NUM_SERVERS_RESET = 5'd16;

	// One request item.
	typedef struct packed {
		logic [ARRIVAL_W-1:0] arrival_time;
		logic [LENGTH_W-1:0]  work_length;
		logic                 is_final_request;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [INDEX_W-1:0]   server_index;
		logic                 was_dropped;
		logic                 is_report;
		logic [BUSIEST_W-1:0] busiest_count;
		logic                 is_last_result;
	} res_t;

endpackage

// ===== rtl/core/rnfsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds per-server tables of the ring server assigner.
module rnfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/ring_next_free_server_assigner.sv =====
// Top level of the ring server assigner: sequencer, scan unit and result register.
// Depends on rnfsa_pkg, rnfsa_ram and ring_next_free_server_assigner_macros.svh.
//
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  rnfsa_pkg::req_t  (one request)
// res      out        res_valid/res_stall  rnfsa_pkg::res_t  (assignment or report)
// cfg      in         cfg_we               cfg_wdata (server count)
//
// A request holds the block from the accept through a scan of all MAX_SERVERS entries
// (registered table read, one compare per entry, a closing step) and an assigning
// state that emits the assignment item; no new request is taken until it is idle.
// A final request then walks the servers in the ring, a read and a check each, to report.
// Reset needs no clearing pass: per-server busy and count-valid bits clear at once.
// A stalled result holds the sequencer only in the cycles that must emit an item.
`include "ring_next_free_server_assigner_macros.svh"

module ring_next_free_server_assigner #(
	parameter int MAX_SERVERS = 16,
	parameter int TIME_BITS   = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  rnfsa_pkg::req_t                     req_data,
	output logic                                res_valid,
	input  logic                                res_stall,
	output rnfsa_pkg::res_t                     res_data,
	input  logic                                cfg_we,
	input  logic [rnfsa_pkg::NUM_SRV_W-1:0]     cfg_wdata
);

	localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = $clog2(MAX_SERVERS + 1);
	localparam int KW = (CW > rnfsa_pkg::NUM_SRV_W) ? CW : rnfsa_pkg::NUM_SRV_W;
	localparam int TW = (TIME_BITS > rnfsa_pkg::ARRIVAL_W) ? TIME_BITS : rnfsa_pkg::ARRIVAL_W;
	localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_UPDATE  = 3'd2;
	localparam logic [2:0] ST_RPT_RD  = 3'd3;
	localparam logic [2:0] ST_RPT_CHK = 3'd4;
	localparam logic [2:0] ST_RPT_END = 3'd5;

	logic [rnfsa_pkg::NUM_SRV_W-1:0] num_servers_q;
	logic [2:0]                      state_q;
	logic [TIME_BITS-1:0]            t_q;
	logic [TIME_BITS-1:0]            len_q;
	logic                            final_q;
	logic [CW-1:0]                   k_q;
	logic [SW-1:0]                   p_q;
	logic [SW-1:0]                   ptr_q;
	logic [CW-1:0]                   scan_q;
	logic                            vld_s1;
	logic [SW-1:0]                   idx_s1;
	logic                            hi_found_q;
	logic                            lo_found_q;
	logic [SW-1:0]                   hi_idx_q;
	logic [SW-1:0]                   lo_idx_q;
	logic [COUNT_BITS-1:0]           hi_cnt_q;
	logic [COUNT_BITS-1:0]           lo_cnt_q;
	logic [MAX_SERVERS-1:0]          busy_q;
	logic [MAX_SERVERS-1:0]          cnt_vld_q;
	logic [COUNT_BITS-1:0]           top_q;
	logic [CW-1:0]                   rs_q;
	logic                            pend_vld_q;
	logic [SW-1:0]                   pend_idx_q;
	logic                            res_valid_q;
	rnfsa_pkg::res_t                 res_q;

	logic                  accept;
	logic [TW-1:0]         arr_w;
	logic [TW-1:0]         len_w;
	logic [TIME_BITS-1:0]  arr_in;
	logic [TIME_BITS-1:0]  len_in;
	logic [KW-1:0]         num_w;
	logic [CW-1:0]         k_in;
	logic [SW-1:0]         p_in;

	logic [SW-1:0]         raddr;
	logic [TIME_BITS-1:0]  bu_rdata;
	logic [COUNT_BITS-1:0] cnt_rdata;

	logic                  scan_issue;
	logic [COUNT_BITS-1:0] scan_cnt;
	logic                  scan_free;
	logic                  scan_in_ring;
	logic                  scan_release;

	logic                  found;
	logic [SW-1:0]         pick;
	logic [COUNT_BITS-1:0] pick_cnt;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [TIME_BITS:0]    end_w;
	logic [TIME_BITS-1:0]  busy_new;
	logic [CW-1:0]         ptr_inc;
	logic [SW-1:0]         ptr_next;

	logic [COUNT_BITS-1:0] rpt_cnt;
	logic                  rpt_hit;

	logic                  slot_free;
	logic                  emit;
	rnfsa_pkg::res_t       emit_item;
	logic                  upd_go;
	logic                  chk_go;
	logic                  end_go;

	// Request intake: saturate times and fix the ring size and start point.
	assign accept = (state_q == ST_IDLE) && req_valid;
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		arr_w  = TW'(req_data.arrival_time);
		len_w  = TW'(req_data.work_length);
		arr_in = (arr_w > TW'(TIME_MAX)) ? TIME_MAX : arr_w[TIME_BITS-1:0];
		len_in = (len_w > TW'(TIME_MAX)) ? TIME_MAX : len_w[TIME_BITS-1:0];
		num_w  = KW'(num_servers_q);
		if (num_w == '0) begin
			k_in = CW'(1);
		end else if (num_w > KW'(MAX_SERVERS)) begin
			k_in = CW'(MAX_SERVERS);
		end else begin
			k_in = CW'(num_w);
		end
		p_in = (CW'(ptr_q) < k_in) ? ptr_q : '0;
	end

	// Per-server tables.
	assign raddr = (state_q == ST_SCAN) ? scan_q[SW-1:0] : rs_q[SW-1:0];

	rnfsa_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_SERVERS)
	) u_busy_until (
		.clk   (clk),
		.we    (upd_go && found),
		.waddr (pick),
		.wdata (busy_new),
		.raddr (raddr),
		.rdata (bu_rdata)
	);

	rnfsa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_SERVERS)
	) u_served_count (
		.clk   (clk),
		.we    (upd_go && found),
		.waddr (pick),
		.wdata (cnt_new),
		.raddr (raddr),
		.rdata (cnt_rdata)
	);

	// Scan step: one compare decides release and whether the server is free.
	always_comb begin
		scan_issue   = (state_q == ST_SCAN) && (scan_q < CW'(MAX_SERVERS));
		scan_cnt     = cnt_vld_q[idx_s1] ? cnt_rdata : '0;
		scan_release = busy_q[idx_s1] && (bu_rdata <= t_q);
		scan_free    = !busy_q[idx_s1] || scan_release;
		scan_in_ring = CW'(idx_s1) < k_q;
	end

	// Assignment step: saturating end time and count, next start pointer.
	always_comb begin
		found    = hi_found_q || lo_found_q;
		pick     = hi_found_q ? hi_idx_q : lo_idx_q;
		pick_cnt = hi_found_q ? hi_cnt_q : lo_cnt_q;
		cnt_new  = (pick_cnt == COUNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
		end_w    = {1'b0, t_q} + {1'b0, len_q};
		busy_new = end_w[TIME_BITS] ? TIME_MAX : end_w[TIME_BITS-1:0];
		ptr_inc  = CW'(p_q) + 1'b1;
		ptr_next = (ptr_inc >= k_q) ? '0 : SW'(ptr_inc);
	end

	// Report step: does the server just read hold the top count.
	always_comb begin
		rpt_cnt = cnt_vld_q[rs_q[SW-1:0]] ? cnt_rdata : '0;
		rpt_hit = (rpt_cnt == top_q);
	end

	// Result selection; a report server is held back one step so the last can be marked.
	assign slot_free = !res_valid_q || !res_stall;

	always_comb begin
		emit_item = '0;
		emit      = 1'b0;
		case (state_q)
			ST_UPDATE: begin
				emit                     = slot_free;
				emit_item.server_index   = found ? rnfsa_pkg::INDEX_W'(pick) : '0;
				emit_item.was_dropped    = !found;
				emit_item.is_last_result = !final_q;
			end
			ST_RPT_CHK, ST_RPT_END: begin
				emit                     = slot_free && pend_vld_q &&
					((state_q == ST_RPT_END) || rpt_hit);
				emit_item.server_index   = rnfsa_pkg::INDEX_W'(pend_idx_q);
				emit_item.is_report      = 1'b1;
				emit_item.busiest_count  = rnfsa_pkg::BUSIEST_W'(top_q);
				emit_item.is_last_result = (state_q == ST_RPT_END);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign upd_go = (state_q == ST_UPDATE) && slot_free;
	assign chk_go = (state_q == ST_RPT_CHK) && (!(rpt_hit && pend_vld_q) || slot_free);
	assign end_go = (state_q == ST_RPT_END) && (!pend_vld_q || slot_free);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			num_servers_q <= rnfsa_pkg::NUM_SERVERS_RESET;
			scan_q        <= '0;
			vld_s1        <= 1'b0;
			hi_found_q    <= 1'b0;
			lo_found_q    <= 1'b0;
			busy_q        <= '0;
			cnt_vld_q     <= '0;
			top_q         <= '0;
			ptr_q         <= '0;
			rs_q          <= '0;
			pend_vld_q    <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_servers_q <= cfg_wdata;
			end

			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q     <= '0;
						vld_s1     <= 1'b0;
						hi_found_q <= 1'b0;
						lo_found_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= scan_issue;
					if (scan_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (vld_s1) begin
						if (scan_release) begin
							busy_q[idx_s1] <= 1'b0;
						end
						if (scan_free && scan_in_ring) begin
							if (idx_s1 >= p_q) begin
								hi_found_q <= 1'b1;
							end else begin
								lo_found_q <= 1'b1;
							end
						end
					end else if (!scan_issue) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						ptr_q <= ptr_next;
						if (found) begin
							busy_q[pick]    <= 1'b1;
							cnt_vld_q[pick] <= 1'b1;
							if (cnt_new > top_q) begin
								top_q <= cnt_new;
							end
						end
						rs_q       <= '0;
						pend_vld_q <= 1'b0;
						state_q    <= final_q ? ST_RPT_RD : ST_IDLE;
					end
				end
				ST_RPT_RD: begin
					state_q <= (rs_q < k_q) ? ST_RPT_CHK : ST_RPT_END;
				end
				ST_RPT_CHK: begin
					if (chk_go) begin
						if (rpt_hit) begin
							pend_vld_q <= 1'b1;
						end
						rs_q    <= rs_q + 1'b1;
						state_q <= ST_RPT_RD;
					end
				end
				ST_RPT_END: begin
					if (end_go) begin
						pend_vld_q <= 1'b0;
						busy_q     <= '0;
						cnt_vld_q  <= '0;
						top_q      <= '0;
						ptr_q      <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, scan pipeline and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q     <= arr_in;
			len_q   <= len_in;
			final_q <= req_data.is_final_request;
			k_q     <= k_in;
			p_q     <= p_in;
		end
		if (scan_issue) begin
			idx_s1 <= scan_q[SW-1:0];
		end
		// The first free server at or after the start point wins, else the first before it.
		if ((state_q == ST_SCAN) && vld_s1 && scan_free && scan_in_ring) begin
			if ((idx_s1 >= p_q) && !hi_found_q) begin
				hi_idx_q <= idx_s1;
				hi_cnt_q <= scan_cnt;
			end
			if ((idx_s1 < p_q) && !lo_found_q) begin
				lo_idx_q <= idx_s1;
				lo_cnt_q <= scan_cnt;
			end
		end
		if (chk_go && rpt_hit) begin
			pend_idx_q <= rs_q[SW-1:0];
		end
		if (emit) begin
			res_q <= emit_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// An assigned server is busy right after the assignment.
	`RNFSA_ASSERT_NEXT(a_pick_busy, clk, arst_n, upd_go && found, busy_q[$past(pick)],
		"assigned server not marked busy")
	// The top count never falls below a count just written.
	`RNFSA_ASSERT_NEXT(a_top_tracks, clk, arst_n, upd_go && found, top_q >= $past(cnt_new),
		"top count below a served count")
	// The end of a report leaves all batch state clear.
	`RNFSA_ASSERT_NEXT(a_batch_clear, clk, arst_n, end_go,
		(top_q == '0) && (busy_q == '0) && (cnt_vld_q == '0) && (ptr_q == '0),
		"batch state not cleared after report")
	// A wrapped candidate always lies before the start point.
	`RNFSA_ASSERT_NOW(a_lo_before_start, clk, arst_n, lo_found_q, lo_idx_q < p_q,
		"wrapped candidate at or after start point")

endmodule
